FILE: sv/header_length_checksum_deframer_assert.svh
// assertion macros for the header/length/checksum deframer
// expects a clock named clk and an active-high reset named rst in scope
`ifndef HEADER_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH
`define HEADER_LENGTH_CHECKSUM_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HLCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HLCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/hlcd_pkg.sv
// shared types and constants for the header/length/checksum deframer
// no dependencies
package hlcd_pkg;

  // framing constants
  localparam logic [7:0] HDR_BYTE        = 8'h7e;
  localparam int         LEN_BYTES       = 4;
  localparam int         DEF_MAX_PAYLOAD = 4096;

  // field widths of a result transaction
  localparam int PLEN_W    = 13;
  localparam int SUM_W     = 16;
  localparam int OUT_DATA_W = 72;

  // receive phase
  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_CMD   = 4'd1,
    PH_EXT   = 4'd2,
    PH_LEN   = 4'd3,
    PH_DATA  = 4'd7,
    PH_SUMHI = 4'd8,
    PH_SUMLO = 4'd9
  } phase_t;

  // result kind carried on tuser
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_OK       = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

endpackage

FILE: sv/header_length_checksum_deframer.sv
// Byte stream deframer: 0x7e header, command, extension, 4-byte length,
// payload and 16-bit additive checksum. An accepted byte is registered in the
// input register, then its result goes to the output register once that is free.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single-pass phase/sum update. Reset (rst, synchronous) empties both registers
// and returns to header hunting with all packet state cleared.
`include "header_length_checksum_deframer_assert.svh"

module header_length_checksum_deframer
  import hlcd_pkg::*;
#(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // rx_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // command, command_ext, payload_length, payload_byte, computed_sum,
  // received_sum, then zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser   // kind
);

  localparam int          CNT_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD + 1) : 1;
  localparam logic [31:0] MAX_LEN   = 32'(MAX_PAYLOAD);
  localparam logic [1:0]  LEN_LAST  = 2'(LEN_BYTES - 1);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // packet state
  phase_t           phase, phase_next;
  logic [7:0]       cmd_reg, cmd_reg_next;
  logic [7:0]       cmd_ext_reg, cmd_ext_reg_next;
  logic [31:0]      length_reg, length_reg_next;
  logic [1:0]       len_count, len_count_next;
  logic [CNT_W-1:0] bytes_left, bytes_left_next;
  logic [SUM_W-1:0] running_sum, running_sum_next;
  logic [7:0]       sum_high_byte, sum_high_byte_next;

  // result of the current byte
  logic              emit;
  kind_t             kind;
  logic [7:0]        pbyte;
  logic [SUM_W-1:0]  rsum;
  logic [PLEN_W-1:0] plen;

  // output register
  logic       out_free;
  logic       fire;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  // phase update and result for one byte
  always_comb begin
    phase_next         = phase;
    cmd_reg_next       = cmd_reg;
    cmd_ext_reg_next   = cmd_ext_reg;
    length_reg_next    = length_reg;
    len_count_next     = len_count;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum + SUM_W'(in_byte);
    sum_high_byte_next = sum_high_byte;
    emit               = 1'b0;
    kind               = KIND_PAYLOAD;
    pbyte              = 8'd0;
    rsum               = '0;
    plen               = length_reg[PLEN_W-1:0];
    case (phase)
      PH_HUNT: begin
        running_sum_next = running_sum;
        if (in_byte == HDR_BYTE) begin
          running_sum_next = SUM_W'(in_byte);
          phase_next       = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_reg_next = in_byte;
        phase_next   = PH_EXT;
      end
      PH_EXT: begin
        cmd_ext_reg_next = in_byte;
        length_reg_next  = '0;
        len_count_next   = LEN_LAST;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        length_reg_next = {length_reg[23:0], in_byte};
        if (len_count != 2'd0) begin
          len_count_next = len_count - 2'd1;
        end else if (length_reg_next > MAX_LEN) begin
          emit       = 1'b1;
          kind       = KIND_TOO_LONG;
          plen       = MAX_LEN[PLEN_W-1:0];
          phase_next = PH_HUNT;
        end else begin
          // length fits the counter once it is not above the limit
          bytes_left_next = length_reg_next[CNT_W-1:0];
          plen            = length_reg_next[PLEN_W-1:0];
          phase_next      = (length_reg_next == 32'd0) ? PH_SUMHI : PH_DATA;
        end
      end
      PH_DATA: begin
        emit            = 1'b1;
        kind            = KIND_PAYLOAD;
        pbyte           = in_byte;
        bytes_left_next = bytes_left - CNT_W'(1);
        if (bytes_left_next == '0) begin
          phase_next = PH_SUMHI;
        end
      end
      PH_SUMHI: begin
        running_sum_next   = running_sum;
        sum_high_byte_next = in_byte;
        phase_next         = PH_SUMLO;
      end
      PH_SUMLO: begin
        running_sum_next = running_sum;
        rsum             = {sum_high_byte, in_byte};
        emit             = 1'b1;
        kind             = (rsum == running_sum) ? KIND_OK : KIND_MISMATCH;
        phase_next       = PH_HUNT;
      end
      default: begin
        running_sum_next = running_sum;
        phase_next       = PH_HUNT;
      end
    endcase
  end

  // packet state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      cmd_reg       <= '0;
      cmd_ext_reg   <= '0;
      length_reg    <= '0;
      len_count     <= '0;
      bytes_left    <= '0;
      running_sum   <= '0;
      sum_high_byte <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      cmd_reg       <= cmd_reg_next;
      cmd_ext_reg   <= cmd_ext_reg_next;
      length_reg    <= length_reg_next;
      len_count     <= len_count_next;
      bytes_left    <= bytes_left_next;
      running_sum   <= running_sum_next;
      sum_high_byte <= sum_high_byte_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= fire && emit;
    end
    if (fire && emit) begin
      m_axis_tuser <= kind;
      m_axis_tdata <= {3'd0, rsum, running_sum_next, pbyte, plen,
                       cmd_ext_reg_next, cmd_reg_next};
    end
  end

  // checks on the deframer's own logic
  `HLCD_ASSERT_IMP(a_data_has_bytes, phase == PH_DATA, bytes_left != '0,
    "payload phase with no bytes left")
  `HLCD_ASSERT_NXT(a_trailer_ends, fire && phase == PH_SUMLO,
    m_axis_tvalid && phase == PH_HUNT, "checksum trailer did not end packet")
  `HLCD_ASSERT_IMP(a_ok_sums_match, m_axis_tvalid && m_axis_tuser == KIND_OK,
    m_axis_tdata[52:37] == m_axis_tdata[68:53], "ok status with unequal sums")
  `HLCD_ASSERT_IMP(a_payload_no_rsum,
    m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD,
    m_axis_tdata[68:53] == 16'd0, "payload result carries a checksum")

endmodule

FILE: verif/tb_top.sv
// testbench for header_length_checksum_deframer: byte stream in, payload and status out
// depends on hlcd_pkg and the deframer RTL; a scoreboard class predicts every result
// and checks it field by field while both stream sides idle at random
module tb_top;
  import hlcd_pkg::*;

  localparam int MAX_PAYLOAD = DEF_MAX_PAYLOAD;

  // bit positions of the result fields in m_axis_tdata
  localparam int CMD_LSB   = 0;
  localparam int EXT_LSB   = 8;
  localparam int PLEN_LSB  = 16;
  localparam int PBYTE_LSB = 29;
  localparam int CSUM_LSB  = 37;
  localparam int RSUM_LSB  = 53;

  // one expected deframer result
  typedef struct {
    kind_t            kind;
    logic [7:0]       command;
    logic [7:0]       command_ext;
    logic [PLEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;
    logic [SUM_W-1:0] computed_sum;
    logic [SUM_W-1:0] received_sum;
  } deframe_result_t;

  // deframer prediction and result checking
  class deframe_scoreboard;
    phase_t           rx_phase = PH_HUNT;
    logic [7:0]       cmd_byte = '0;
    logic [7:0]       ext_byte = '0;
    logic [31:0]      declared_len = '0;
    logic [31:0]      remaining = '0;
    logic [SUM_W-1:0] byte_sum = '0;
    logic [7:0]       sum_high = '0;
    deframe_result_t  results_due[$];
    int               mismatches = 0;

    function int pending();
      return results_due.size();
    endfunction

    function void add_result(kind_t k, logic [7:0] pbyte, logic [SUM_W-1:0] rsum);
      deframe_result_t r;
      r.kind           = k;
      r.command        = cmd_byte;
      r.command_ext    = ext_byte;
      r.payload_length = (declared_len > 32'(MAX_PAYLOAD)) ? PLEN_W'(MAX_PAYLOAD)
                                                           : declared_len[PLEN_W-1:0];
      r.payload_byte   = pbyte;
      r.computed_sum   = byte_sum;
      r.received_sum   = rsum;
      results_due.push_back(r);
    endfunction

    // advance the framing state by one accepted byte
    function void note_rx_byte(logic [7:0] b);
      logic [SUM_W-1:0] rsum;
      case (rx_phase)
        PH_HUNT: begin
          if (b == HDR_BYTE) begin
            byte_sum = SUM_W'(b);
            rx_phase = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_byte = b;
          byte_sum = byte_sum + SUM_W'(b);
          rx_phase = PH_EXT;
        end
        PH_EXT: begin
          ext_byte     = b;
          byte_sum     = byte_sum + SUM_W'(b);
          declared_len = '0;
          remaining    = LEN_BYTES;
          rx_phase     = PH_LEN;
        end
        PH_LEN: begin
          declared_len = {declared_len[23:0], b};
          byte_sum     = byte_sum + SUM_W'(b);
          if (remaining > 0) remaining = remaining - 1;
          if (remaining == 0) begin
            if (declared_len > 32'(MAX_PAYLOAD)) begin
              add_result(KIND_TOO_LONG, 8'h00, '0);
              rx_phase = PH_HUNT;
            end else begin
              remaining = declared_len;
              rx_phase  = (declared_len == 0) ? PH_SUMHI : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          byte_sum = byte_sum + SUM_W'(b);
          add_result(KIND_PAYLOAD, b, '0);
          if (remaining > 0) remaining = remaining - 1;
          if (remaining == 0) rx_phase = PH_SUMHI;
        end
        PH_SUMHI: begin
          sum_high = b;
          rx_phase = PH_SUMLO;
        end
        PH_SUMLO: begin
          rsum = {sum_high, b};
          add_result((rsum == byte_sum) ? KIND_OK : KIND_MISMATCH, 8'h00, rsum);
          rx_phase = PH_HUNT;
        end
        default: rx_phase = PH_HUNT;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic [1:0] u);
      deframe_result_t r;
      if (results_due.size() == 0) begin
        $error("unexpected result transaction: kind %0h, tdata %0h", u, d);
        mismatches++;
        return;
      end
      r = results_due.pop_front();
      compare_field("kind", 16'(r.kind), 16'(u));
      compare_field("command", 16'(r.command), 16'(d[CMD_LSB +: 8]));
      compare_field("command_ext", 16'(r.command_ext), 16'(d[EXT_LSB +: 8]));
      compare_field("payload_length", 16'(r.payload_length), 16'(d[PLEN_LSB +: PLEN_W]));
      compare_field("payload_byte", 16'(r.payload_byte), 16'(d[PBYTE_LSB +: 8]));
      compare_field("computed_sum", r.computed_sum, d[CSUM_LSB +: SUM_W]);
      compare_field("received_sum", r.received_sum, d[RSUM_LSB +: SUM_W]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  deframe_scoreboard sb = new;
  logic [7:0]        frame_bytes[$];
  bit                send_burst = 1'b0;
  bit                recv_burst = 1'b0;

  header_length_checksum_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // append one frame; lengths above the limit stop after the length field
  function automatic void add_packet(logic [7:0] cmd, logic [7:0] ext, logic [31:0] len,
                                     bit bad_sum, bit hdr_fill);
    logic [SUM_W-1:0] s;
    logic [7:0]       pb;
    s = SUM_W'(HDR_BYTE) + SUM_W'(cmd) + SUM_W'(ext);
    frame_bytes.push_back(HDR_BYTE);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(ext);
    for (int i = 3; i >= 0; i--) begin
      frame_bytes.push_back(len[8*i +: 8]);
      s = s + SUM_W'(len[8*i +: 8]);
    end
    if (len > 32'(MAX_PAYLOAD)) return;
    for (int i = 0; i < len; i++) begin
      pb = hdr_fill ? HDR_BYTE : 8'($urandom);
      frame_bytes.push_back(pb);
      s = s + SUM_W'(pb);
    end
    if (bad_sum) s = s ^ 16'($urandom_range(1, 65535));
    frame_bytes.push_back(s[15:8]);
    frame_bytes.push_back(s[7:0]);
  endfunction

  // one byte transaction on the input stream
  task automatic send_byte(logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready === 1'b1));
    sb.note_rx_byte(b);
  endtask

  task automatic send_frames();
    while (frame_bytes.size() > 0) send_byte(frame_bytes.pop_front());
  endtask

  // result side: random stalls, check every transaction
  initial begin
    int gap;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready));
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // stimulus
  initial begin
    int   framed;
    int   pick;
    int   n;
    logic [31:0] len;
    framed   = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // noise while hunting, then zero length, header bytes as payload, bad checksum
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hff);
    add_packet(8'hff, 8'h00, 32'd0, 1'b0, 1'b0);
    add_packet(8'h00, 8'hff, 32'd2, 1'b0, 1'b1);
    add_packet(8'h5a, 8'ha5, 32'd1, 1'b1, 1'b0);
    // too long just past the limit, with the next header right behind it
    add_packet(8'h12, 8'h34, 32'(MAX_PAYLOAD) + 1, 1'b0, 1'b0);
    add_packet(8'h80, 8'h01, 32'hffff_ffff, 1'b0, 1'b0);
    add_packet(8'h7e, 8'h7e, 32'd3, 1'b0, 1'b0);
    send_frames();

    // random traffic, mostly well-formed frames
    while (framed < 750) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        n = $urandom_range(0, 99);
        len = (n < 80) ? $urandom_range(0, 16) :
              (n < 96) ? $urandom_range(17, 64) : $urandom_range(65, 200);
        add_packet(8'($urandom), 8'($urandom), len, $urandom_range(0, 3) == 0, 1'b0);
        framed += frame_bytes.size();
      end else if (pick < 72) begin
        len = $urandom_range(0, 1) ? 32'(MAX_PAYLOAD) + 1 + $urandom_range(0, 255)
                                   : ($urandom | 32'h0100_0000);
        add_packet(8'($urandom), 8'($urandom), len, 1'b0, 1'b0);
        framed += frame_bytes.size();
      end else if (pick < 84) begin
        // header followed by a cut-off frame
        frame_bytes.push_back(HDR_BYTE);
        repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
        framed += frame_bytes.size();
      end else begin
        repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
      end
      send_frames();
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
